>>> sv/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, cond)

`endif

`endif

>>> sv/pas_pkg.sv
package pas_pkg;

  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned TGT_BITS  = 32;

  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic [1:0] CTR_MIN = 2'b00;

  typedef enum logic [0:0] {
    FUNC_PREDICT = 1'b0,
    FUNC_UPDATE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE
  } state_e;

  typedef struct packed {
    func_e                 func;
    logic [ADDR_BITS-1:0]  address;
    logic                  is_direct;
    logic [TGT_BITS-1:0]   target;
    logic                  outcome_taken;
  } pas_in_t;

  typedef struct packed {
    logic                  predict_taken;
    logic [TGT_BITS-1:0]   predict_target;
  } pas_out_t;

  // control from the sequencer to the pattern table
  typedef struct packed {
    logic rd_en;
    logic upd_en;
    logic upd_taken;
  } pht_ctl_t;

endpackage

>>> sv/pas_two_level_branch_predictor.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i   (func, address, target, ...)
// out     | output    | out_valid_o / out_stall_i| out_item_o  (predict_taken, predict_target)
//
// an item from idle goes through accept with history read, counter read, resolve
// items back to back overlap: the next item is taken on the resolve cycle
// the two dependent memory reads (history then counter) set the item time
// after reset a clearing pass over a max(HIST_INDEX_BITS, TABLE_SELECT_BITS+HISTORY_BITS) bit index
// zeroes both memories; no item is taken meanwhile
// a predict result waits in the output register; while it is stalled the next predict
// cannot resolve, so input stall rises
`include "assert_macros.svh"

module pas_two_level_branch_predictor #(
  parameter int unsigned HIST_INDEX_BITS   = 8,
  parameter int unsigned TABLE_SELECT_BITS = 4,
  parameter int unsigned HISTORY_BITS      = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pas_pkg::pas_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pas_pkg::pas_out_t out_item_o
);
  import pas_pkg::*;

  localparam int unsigned CTR_IDX_BITS = TABLE_SELECT_BITS + HISTORY_BITS;
  localparam int unsigned CLR_BITS     =
    (HIST_INDEX_BITS > CTR_IDX_BITS) ? HIST_INDEX_BITS : CTR_IDX_BITS;
  localparam int unsigned HIST_DEPTH   = 2 ** HIST_INDEX_BITS;

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   out_free;
  logic   is_upd;
  logic   resolve_done;
  logic   hist_wr;

  // item in flight
  pas_in_t item_q;

  // local history memory
  logic [HISTORY_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [HISTORY_BITS-1:0] hist_rd_q;
  logic [HISTORY_BITS-1:0] hist_cur;
  logic [HISTORY_BITS-1:0] hist_q;
  logic [HISTORY_BITS:0]   hist_shift;
  logic [HISTORY_BITS-1:0] hist_new;

  // write-back forwarding for an item taken on the resolve cycle
  logic                    fwd_q;
  logic [HISTORY_BITS-1:0] fwd_hist_q;

  logic [TGT_BITS-1:0] last_tgt_q;

  // pattern table interface
  pht_ctl_t              pht_ctl;
  logic [CTR_IDX_BITS-1:0] ctr_idx;
  logic [1:0]            ctr;
  logic                  clr_busy;
  logic [CLR_BITS-1:0]   clr_idx;

  // output register
  logic     out_valid_q;
  pas_out_t out_item_q;

  assign is_upd       = (item_q.func == FUNC_UPDATE);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign resolve_done = (state_q == ST_RESOLVE) && (is_upd || out_free);
  assign in_stall_o   = !((state_q == ST_IDLE) || resolve_done);
  assign accept       = in_valid_i && !in_stall_o;
  assign hist_wr      = resolve_done && is_upd;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (resolve_done) begin
          state_d = accept ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // outputs of the sequencer toward the pattern table
  always_comb begin
    pht_ctl.rd_en     = (state_q == ST_LOOKUP);
    pht_ctl.upd_en    = hist_wr;
    pht_ctl.upd_taken = item_q.outcome_taken;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // history: sweep on reset, write back on update, read on accept
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      hist_mem[clr_idx[HIST_INDEX_BITS-1:0]] <= '0;
    end else if (hist_wr) begin
      hist_mem[item_q.address[HIST_INDEX_BITS-1:0]] <= hist_new;
    end
    if (accept) begin
      hist_rd_q <= hist_mem[in_item_i.address[HIST_INDEX_BITS-1:0]];
    end
  end

  // the read at the resolve edge misses the write-back of the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= accept && hist_wr &&
               (in_item_i.address[HIST_INDEX_BITS-1:0] ==
                item_q.address[HIST_INDEX_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_wr) begin
      fwd_hist_q <= hist_new;
    end
  end

  assign hist_cur = fwd_q ? fwd_hist_q : hist_rd_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) begin
      hist_q <= hist_cur;
    end
  end

  // oldest bit falls out, outcome enters at bit 0
  assign hist_shift = {hist_q, item_q.outcome_taken};
  assign hist_new   = hist_shift[HISTORY_BITS-1:0];

  // pattern table picked by the top address bits, entry by the history
  assign ctr_idx = {item_q.address[ADDR_BITS-1 -: TABLE_SELECT_BITS], hist_cur};

  pas_pht #(
    .IDX_BITS (CTR_IDX_BITS),
    .CLR_BITS (CLR_BITS)
  ) u_pht (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (pht_ctl),
    .rd_idx_i   (ctr_idx),
    .ctr_o      (ctr),
    .clr_busy_o (clr_busy),
    .clr_idx_o  (clr_idx)
  );

  // only a taken indirect branch moves the stored target
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tgt_q <= '0;
    end else if (hist_wr && item_q.outcome_taken && !item_q.is_direct) begin
      last_tgt_q <= item_q.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resolve_done && !is_upd) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve_done && !is_upd) begin
      out_item_q.predict_taken  <= ctr[1];
      out_item_q.predict_target <= item_q.is_direct ? item_q.target : last_tgt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_CLK(a_clear_blocks_input, clk_i, rst_ni, (state_q == ST_CLEAR) |-> in_stall_o)
  `ASSERT_CLK(a_lookup_then_resolve, clk_i, rst_ni, (state_q == ST_LOOKUP) |=> (state_q == ST_RESOLVE))
  `ASSERT_CLK(a_fwd_only_in_lookup, clk_i, rst_ni, fwd_q |-> (state_q == ST_LOOKUP))
  `ASSERT_CLK(a_result_from_predict, clk_i, rst_ni, $rose(out_valid_q) |-> $past((state_q == ST_RESOLVE) && !is_upd))

endmodule

>>> sv/pas_pht.sv
`include "assert_macros.svh"

module pas_pht #(
  parameter int unsigned IDX_BITS = 16,
  parameter int unsigned CLR_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pas_pkg::pht_ctl_t      ctl_i,
  input  logic [IDX_BITS-1:0]    rd_idx_i,
  output logic [1:0]             ctr_o,
  output logic                   clr_busy_o,
  output logic [CLR_BITS-1:0]    clr_idx_o
);
  import pas_pkg::*;

  localparam int unsigned DEPTH = 2 ** IDX_BITS;

  logic [1:0]          ctr_mem [DEPTH];
  logic [1:0]          ctr_rd_q;
  logic [IDX_BITS-1:0] idx_q;
  logic [1:0]          ctr_next;

  logic [CLR_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                clr_busy_q, clr_busy_d;

  // reset sweep over the whole table, one entry a cycle
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // saturating step toward the resolved direction
  always_comb begin
    ctr_next = ctr_rd_q;
    if (ctl_i.upd_taken) begin
      if (ctr_rd_q != CTR_MAX) begin
        ctr_next = ctr_rd_q + 2'd1;
      end
    end else begin
      if (ctr_rd_q != CTR_MIN) begin
        ctr_next = ctr_rd_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      ctr_mem[clr_cnt_q[IDX_BITS-1:0]] <= CTR_MIN;
    end else if (ctl_i.upd_en) begin
      ctr_mem[idx_q] <= ctr_next;
    end
    if (ctl_i.rd_en) begin
      ctr_rd_q <= ctr_mem[rd_idx_i];
      idx_q    <= rd_idx_i;
    end
  end

  assign ctr_o      = ctr_rd_q;
  assign clr_busy_o = clr_busy_q;
  assign clr_idx_o  = clr_cnt_q;

  `ASSERT_NEVER(a_no_access_in_sweep, clk_i, rst_ni, clr_busy_q && (ctl_i.rd_en || ctl_i.upd_en))
  `ASSERT_NEVER(a_no_rd_and_upd, clk_i, rst_ni, ctl_i.rd_en && ctl_i.upd_en)
  `ASSERT_CLK(a_sweep_ends_once, clk_i, rst_ni, !clr_busy_q |=> !clr_busy_q)

endmodule
